// ===== src/ghc_pkg.sv =====
// Package for the gear hash chunk boundary block: widths, codes, payload types
// and the constant gear table built by splitmix64 at elaboration.
// Used by every module under src; depends on nothing.
package ghc_pkg;

  // Width of the chunk length counter and of the length registers.
  localparam int LENGTH_WIDTH = 25;
  localparam logic [LENGTH_WIDTH-1:0] LEN_LIMIT = {LENGTH_WIDTH{1'b1}};

  // Configuration port geometry.
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int MASK_BITS_WIDTH = 6;
  localparam int CFG_DATA_WIDTH  =
    (LENGTH_WIDTH > MASK_BITS_WIDTH) ? LENGTH_WIDTH : MASK_BITS_WIDTH;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_CHUNK_LEN = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_CHUNK_LEN = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MASK_BITS     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [LENGTH_WIDTH-1:0]    MIN_LEN_RESET   = LENGTH_WIDTH'(2048);
  localparam logic [LENGTH_WIDTH-1:0]    MAX_LEN_RESET   = LENGTH_WIDTH'(65536);
  localparam logic [MASK_BITS_WIDTH-1:0] MASK_BITS_RESET = MASK_BITS_WIDTH'(13);

  // Hash and offset widths.
  localparam int HASH_WIDTH   = 64;
  localparam int OFFSET_WIDTH = 32;

  // Splitmix64 constants.
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
  localparam int          GEAR_ENTRIES = 256;

  // Reason for a cut.
  typedef enum logic [1:0] {
    CUT_HASH = 2'd0,
    CUT_MAX  = 2'd1,
    CUT_END  = 2'd2
  } cut_kind_t;

  // Input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [OFFSET_WIDTH-1:0] chunk_offset;
    logic [LENGTH_WIDTH-1:0] chunk_length;
    cut_kind_t               cut_kind;
    logic                    final_chunk;
  } out_item_t;

  // Byte after the table lookup, between the gear stage and the chunker.
  typedef struct packed {
    logic [HASH_WIDTH-1:0] gear;
    logic                  is_last;
  } gear_item_t;

  // Configuration as seen by the chunker; the mask is kept expanded.
  typedef struct packed {
    logic [LENGTH_WIDTH-1:0] min_chunk_len;
    logic [LENGTH_WIDTH-1:0] max_chunk_len;
    logic [HASH_WIDTH-1:0]   hash_mask;
  } cfg_t;

  typedef logic [HASH_WIDTH-1:0] gear_table_t [GEAR_ENTRIES];

  // Splitmix64 output for table entry b; evaluated only at elaboration.
  function automatic logic [63:0] gear_value(input int unsigned b);
    logic [63:0] z;
    z = (64'(b) + 64'd2) * GOLDEN_GAMMA;
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  function automatic gear_table_t gear_build();
    gear_table_t t;
    for (int unsigned i = 0; i < GEAR_ENTRIES; i++) begin
      t[i] = gear_value(i);
    end
    return t;
  endfunction

  localparam gear_table_t GEAR_TABLE = gear_build();

endpackage

// ===== src/gear_hash_chunk_boundary.sv =====
// Top level of the gear hash chunk boundary block: content-defined chunking of a byte stream.
// Instantiates ghc_cfg_regs, ghc_gear_stage and ghc_chunker; depends on ghc_pkg.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   in_item   (data_byte, is_last)
//   out      out_valid / out_ready out_item  (chunk_offset, chunk_length, cut_kind, final_chunk)
//   cfg      cfg_we                cfg_index, cfg_data
//
// One byte is accepted every cycle while results are taken. A byte passes the input register
// with the gear lookup and then the result register before its result can be taken. The rate is
// set by the hash recurrence, a 64-bit shift and add with the mask compare, done once per cycle
// in the chunker.
// While a result waits with out_ready low, one more byte is held in the input register
// and then in_ready drops. Reset is synchronous and loads the register reset values.
module gear_hash_chunk_boundary (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ghc_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ghc_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [ghc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ghc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  ghc_pkg::cfg_t       cfg;
  logic                gear_valid;
  logic                gear_ready;
  ghc_pkg::gear_item_t gear_item;

  // Configuration registers.
  ghc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register with gear lookup.
  ghc_gear_stage u_gear_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .gear_valid (gear_valid),
    .gear_ready (gear_ready),
    .gear_item  (gear_item)
  );

  // Hash, cut decision and result register.
  ghc_chunker u_chunker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .gear_valid (gear_valid),
    .gear_ready (gear_ready),
    .gear_item  (gear_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// ===== src/ghc_cfg_regs.sv =====
// Configuration registers of the gear hash chunk boundary block.
// Holds the length limits and the expanded hash mask; depends on ghc_pkg.
module ghc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ghc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ghc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output ghc_pkg::cfg_t                       cfg
);

  logic [ghc_pkg::LENGTH_WIDTH-1:0] min_chunk_len;
  logic [ghc_pkg::LENGTH_WIDTH-1:0] max_chunk_len;
  logic [ghc_pkg::HASH_WIDTH-1:0]   hash_mask;

  // Register writes; the mask bit count is expanded to a mask when written.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_chunk_len <= ghc_pkg::MIN_LEN_RESET;
      max_chunk_len <= ghc_pkg::MAX_LEN_RESET;
      hash_mask     <= (ghc_pkg::HASH_WIDTH'(1) << ghc_pkg::MASK_BITS_RESET)
                       - ghc_pkg::HASH_WIDTH'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        ghc_pkg::CFG_MIN_CHUNK_LEN: begin
          min_chunk_len <= cfg_data[ghc_pkg::LENGTH_WIDTH-1:0];
        end
        ghc_pkg::CFG_MAX_CHUNK_LEN: begin
          max_chunk_len <= cfg_data[ghc_pkg::LENGTH_WIDTH-1:0];
        end
        ghc_pkg::CFG_MASK_BITS: begin
          hash_mask <= (ghc_pkg::HASH_WIDTH'(1) << cfg_data[ghc_pkg::MASK_BITS_WIDTH-1:0])
                       - ghc_pkg::HASH_WIDTH'(1);
        end
        default: begin
          // Writes beyond the register list are ignored.
        end
      endcase
    end
  end

  assign cfg.min_chunk_len = min_chunk_len;
  assign cfg.max_chunk_len = max_chunk_len;
  assign cfg.hash_mask     = hash_mask;

endmodule

// ===== src/ghc_gear_stage.sv =====
// Input register of the gear hash chunk boundary block with the gear table lookup.
// Depends on ghc_pkg for the item types and the constant table.
module ghc_gear_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ghc_pkg::in_item_t   in_item,
  output logic                gear_valid,
  input  logic                gear_ready,
  output ghc_pkg::gear_item_t gear_item
);

  logic                valid;
  ghc_pkg::gear_item_t item;

  // The stage takes a new item when empty or when its item moves on.
  assign in_ready = !valid || gear_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (gear_ready) begin
      valid <= 1'b0;
    end
  end

  // Look the byte up in the gear table as it is registered.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.gear    <= ghc_pkg::GEAR_TABLE[in_item.data_byte];
      item.is_last <= in_item.is_last;
    end
  end

  assign gear_valid = valid;
  assign gear_item  = item;

endmodule

// ===== src/ghc_chunker.sv =====
// Rolling hash, chunk length counter and result register of the chunk boundary block.
// Depends on ghc_pkg for the item and configuration types and the cut codes.
module ghc_chunker (
  input  logic                clk,
  input  logic                rst,
  input  ghc_pkg::cfg_t       cfg,
  input  logic                gear_valid,
  output logic                gear_ready,
  input  ghc_pkg::gear_item_t gear_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ghc_pkg::out_item_t  out_item
);

  logic [ghc_pkg::HASH_WIDTH-1:0]   rolling_hash;
  logic [ghc_pkg::LENGTH_WIDTH-1:0] bytes_in_chunk;
  logic [ghc_pkg::OFFSET_WIDTH-1:0] chunk_start;
  logic                             result_valid;
  ghc_pkg::out_item_t               result;

  logic [ghc_pkg::HASH_WIDTH-1:0]   hash_next;
  logic [ghc_pkg::LENGTH_WIDTH-1:0] len_next;
  logic                             hash_hit;
  logic                             max_hit;
  logic                             cut;
  logic                             advance;
  ghc_pkg::cut_kind_t               kind;

  // An item moves on when the result register is free or being emptied.
  assign gear_ready = !result_valid || out_ready;
  assign advance    = gear_valid && gear_ready;

  // Hash update, length count and cut decision for the waiting item.
  always_comb begin
    hash_next = {rolling_hash[ghc_pkg::HASH_WIDTH-2:0], 1'b0} + gear_item.gear;
    len_next  = (bytes_in_chunk < ghc_pkg::LEN_LIMIT) ?
                bytes_in_chunk + ghc_pkg::LENGTH_WIDTH'(1) : bytes_in_chunk;
    hash_hit  = (len_next >= cfg.min_chunk_len) &&
                ((hash_next & cfg.hash_mask) == '0);
    max_hit   = (len_next >= cfg.max_chunk_len) || (len_next == ghc_pkg::LEN_LIMIT);
    cut       = hash_hit || max_hit || gear_item.is_last;
    if (hash_hit) begin
      kind = ghc_pkg::CUT_HASH;
    end else if (max_hit) begin
      kind = ghc_pkg::CUT_MAX;
    end else begin
      kind = ghc_pkg::CUT_END;
    end
  end

  // Chunk state: restarts after every cut, offset returns to zero after a file.
  always_ff @(posedge clk) begin
    if (rst) begin
      rolling_hash   <= '0;
      bytes_in_chunk <= '0;
      chunk_start    <= '0;
    end else if (advance) begin
      if (cut) begin
        rolling_hash   <= '0;
        bytes_in_chunk <= '0;
        chunk_start    <= gear_item.is_last ? '0 :
                          chunk_start + ghc_pkg::OFFSET_WIDTH'(len_next);
      end else begin
        rolling_hash   <= hash_next;
        bytes_in_chunk <= len_next;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= cut;
    end else if (out_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload, loaded on each cut.
  always_ff @(posedge clk) begin
    if (advance && cut) begin
      result.chunk_offset <= chunk_start;
      result.chunk_length <= len_next;
      result.cut_kind     <= kind;
      result.final_chunk  <= gear_item.is_last;
    end
  end

  assign out_valid = result_valid;
  assign out_item  = result;

`ifndef SYNTHESIS
  // The stored count never reaches the saturation value; reaching it cuts.
  a_count_below_limit: assert property (@(posedge clk) disable iff (rst)
    bytes_in_chunk != ghc_pkg::LEN_LIMIT)
    else $error("chunk length counter reached its limit without a cut");

  // A cut restarts both the hash and the length count.
  a_cut_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && cut |=> rolling_hash == '0 && bytes_in_chunk == '0)
    else $error("hash or length not cleared after a cut");

  // The byte that ends a file always leaves the offset at zero.
  a_file_end_offset: assert property (@(posedge clk) disable iff (rst)
    advance && gear_item.is_last |=> chunk_start == '0)
    else $error("chunk offset not cleared at end of file");

  // A result never reports an empty chunk.
  a_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.chunk_length != '0)
    else $error("result with zero chunk length");

  // An end-of-data cut always marks the final chunk.
  a_end_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.cut_kind == ghc_pkg::CUT_END |-> out_item.final_chunk)
    else $error("end-of-data cut without final chunk flag");
`endif

endmodule

// ===== sim/ghc_chunk_check.sv =====
// Chunk boundary checker: mirrors the configuration writes, predicts every chunk cut
// from the accepted bytes and compares it with the results taken from the block.
// Depends on ghc_pkg for the payload types, register indexes and reset values.
module ghc_chunk_check (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  ghc_pkg::in_item_t                   in_item,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  ghc_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [ghc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ghc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                                  chunks_pending,
  output int                                  error_count
);
  import ghc_pkg::*;

  // Mirrored configuration registers.
  logic [LENGTH_WIDTH-1:0]    min_len;
  logic [LENGTH_WIDTH-1:0]    max_len;
  logic [MASK_BITS_WIDTH-1:0] mask_width;

  // Predicted chunker state.
  logic [63:0]             hash;
  logic [LENGTH_WIDTH-1:0] run_len;
  logic [31:0]             start_offset;

  // Cuts predicted but not yet seen on the output.
  out_item_t chunk_q[$];
  int        errs;

  // Gear table entry for one byte: the splitmix64 finalizer of (b + 2) times the golden gamma.
  function automatic logic [63:0] gear_of(input logic [7:0] b);
    logic [63:0] z;
    z = ({56'd0, b} + 64'd2) * 64'h9E37_79B9_7F4A_7C15;
    z = (z ^ (z >> 30)) * 64'hBF58_476D_1CE4_E5B9;
    z = (z ^ (z >> 27)) * 64'h94D0_49BB_1331_11EB;
    return z ^ (z >> 31);
  endfunction

  always @(posedge clk) begin : track
    logic [63:0]             mask;
    logic [LENGTH_WIDTH-1:0] len;
    logic                    cut;
    out_item_t               want;
    out_item_t               got;
    if (rst) begin
      min_len      = MIN_LEN_RESET;
      max_len      = MAX_LEN_RESET;
      mask_width   = MASK_BITS_RESET;
      hash         = '0;
      run_len      = '0;
      start_offset = '0;
      chunk_q.delete();
      errs = 0;
    end else begin
      // Track register writes exactly as the block sees them.
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_CHUNK_LEN: min_len = cfg_data[LENGTH_WIDTH-1:0];
          CFG_MAX_CHUNK_LEN: max_len = cfg_data[LENGTH_WIDTH-1:0];
          CFG_MASK_BITS:     mask_width = cfg_data[MASK_BITS_WIDTH-1:0];
          default: ;
        endcase
      end

      // Fold the accepted byte into the hash and decide whether it ends a chunk.
      // A hash match beats the length limit, which beats end of file.
      if (in_valid && in_ready) begin
        hash = (hash << 1) + gear_of(in_item.data_byte);
        len  = run_len;
        if (len != LEN_LIMIT) begin
          len = len + 1'b1;
        end
        mask = (64'd1 << mask_width) - 64'd1;
        want.chunk_offset = start_offset;
        want.chunk_length = len;
        want.final_chunk  = in_item.is_last;
        want.cut_kind     = CUT_END;
        cut = 1'b1;
        if (len >= min_len && (hash & mask) == 64'd0) begin
          want.cut_kind = CUT_HASH;
        end else if (len >= max_len || len == LEN_LIMIT) begin
          want.cut_kind = CUT_MAX;
        end else if (!in_item.is_last) begin
          cut = 1'b0;
        end
        if (cut) begin
          chunk_q.push_back(want);
          start_offset = in_item.is_last ? 32'd0 : start_offset + 32'(len);
          hash    = '0;
          run_len = '0;
        end else begin
          run_len = len;
        end
      end

      // Compare each delivered chunk with the oldest prediction.
      if (out_valid && out_ready) begin
        got = out_item;
        if (chunk_q.size() == 0) begin
          $error("unexpected chunk: offset %0d length %0d kind %0d final %0d",
                 got.chunk_offset, got.chunk_length, got.cut_kind, got.final_chunk);
          errs++;
        end else begin
          want = chunk_q.pop_front();
          if (got.chunk_offset !== want.chunk_offset) begin
            $error("chunk_offset: expected %0d, got %0d", want.chunk_offset, got.chunk_offset);
            errs++;
          end
          if (got.chunk_length !== want.chunk_length) begin
            $error("chunk_length: expected %0d, got %0d", want.chunk_length, got.chunk_length);
            errs++;
          end
          if (got.cut_kind !== want.cut_kind) begin
            $error("cut_kind: expected %0d, got %0d", want.cut_kind, got.cut_kind);
            errs++;
          end
          if (got.final_chunk !== want.final_chunk) begin
            $error("final_chunk: expected %0d, got %0d", want.final_chunk, got.final_chunk);
            errs++;
          end
        end
      end
    end
    chunks_pending <= chunk_q.size();
    error_count    <= errs;
  end

endmodule

// ===== sim/gear_hash_chunk_boundary_tb.sv =====
// Testbench top for the gear hash chunk boundary block: drives byte files and register
// settings, applies random back-pressure and gives the verdict.
// Depends on ghc_pkg, gear_hash_chunk_boundary and ghc_chunk_check.
module gear_hash_chunk_boundary_tb;
  import ghc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 4;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  in_item_t                   in_item;
  logic                       out_valid;
  logic                       out_ready;
  out_item_t                  out_item;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  int chunks_pending;
  int error_count;
  int results_taken;
  int idle_cycles;
  int items_sent;
  bit sender_gaps;

  gear_hash_chunk_boundary uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ghc_chunk_check chunk_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .chunks_pending (chunks_pending),
    .error_count    (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none at all in steady phases.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!sender_gaps || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte and hold it until the block takes it.
  task automatic push_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_item.data_byte <= b;
    in_item.is_last   <= lst;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // One whole file of random bytes; some files use only the two extreme byte values.
  task automatic send_file(input int nbytes);
    bit         extremes;
    logic [7:0] b;
    extremes = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < nbytes; i++) begin
      b = extremes ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
      push_byte(b, i == nbytes - 1);
    end
  endtask

  // Let every expected chunk arrive and the pipeline empty before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (chunks_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [LENGTH_WIDTH-1:0] min_len,
                             input logic [LENGTH_WIDTH-1:0] max_len,
                             input logic [MASK_BITS_WIDTH-1:0] mask_width);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_CHUNK_LEN;
    cfg_data  <= CFG_DATA_WIDTH'(min_len);
    @(posedge clk);
    cfg_index <= CFG_MAX_CHUNK_LEN;
    cfg_data  <= CFG_DATA_WIDTH'(max_len);
    @(posedge clk);
    cfg_index <= CFG_MASK_BITS;
    cfg_data  <= CFG_DATA_WIDTH'(mask_width);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus: directed corner cases, then random phases under random settings.
  initial begin
    int                         r;
    int                         phase_start;
    logic [LENGTH_WIDTH-1:0]    min_len;
    logic [LENGTH_WIDTH-1:0]    max_len;
    logic [MASK_BITS_WIDTH-1:0] mask_width;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_item     <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    items_sent  = 0;
    sender_gaps = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: short files end only at end of data.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
    push_byte(8'hFF, 1'b1);

    // Maximum of zero: every byte is its own chunk, even the last one.
    settle();
    load_config('0, '0, 6'd63);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);

    // No mask bits and no minimum: every byte is a hash cut, winning over end of data.
    settle();
    load_config('0, LEN_LIMIT, 6'd0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b1);

    // Minimum above maximum: only length cuts, and the length cut wins over end of data.
    settle();
    load_config(LENGTH_WIDTH'(5), LENGTH_WIDTH'(3), 6'd0);
    for (int i = 0; i < 6; i++) begin
      push_byte(8'($urandom_range(0, 255)), i == 5);
    end

    // Largest registers: the whole file is one chunk.
    settle();
    load_config(LEN_LIMIT, LEN_LIMIT, 6'd63);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h7F, 1'b1);

    // Random phases; the first one is tuned for frequent hash cuts.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      if (phase == 0) begin
        min_len    = LENGTH_WIDTH'($urandom_range(0, 8));
        max_len    = LENGTH_WIDTH'(64);
        mask_width = 6'd3;
      end else begin
        r = $urandom_range(0, 9);
        min_len = (r == 0) ? '0 : (r == 1) ? LEN_LIMIT : (r == 2) ? LENGTH_WIDTH'(1) :
                  LENGTH_WIDTH'($urandom_range(2, 48));
        r = $urandom_range(0, 9);
        max_len = (r == 0) ? '0 : (r == 1) ? LEN_LIMIT : (r == 2) ? LENGTH_WIDTH'(1) :
                  LENGTH_WIDTH'($urandom_range(8, 96));
        r = $urandom_range(0, 9);
        mask_width = (r == 0) ? 6'd0 : (r == 1) ? 6'd63 : 6'($urandom_range(1, 6));
      end
      load_config(min_len, max_len, mask_width);
      sender_gaps = ($urandom_range(0, 3) != 0);
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          send_file(1);
        end else if (r < 15) begin
          send_file($urandom_range(2, 40));
        end else if (r < 19) begin
          send_file($urandom_range(41, 150));
        end else begin
          send_file($urandom_range(151, 400));
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: random stalls of mixed length, and one long hold while bytes keep coming.
  initial begin
    int r;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!held && results_taken >= 150 && in_valid) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (r < 50) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else if (r < 85) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (r < 97) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(4, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  // Count delivered chunks and stop the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      results_taken <= 0;
    end else if (out_valid && out_ready) begin
      results_taken <= results_taken + 1;
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
